@@ sv/real_input_dft_engine_defines.svh @@
`ifndef REAL_INPUT_DFT_ENGINE_DEFINES_SVH
`define REAL_INPUT_DFT_ENGINE_DEFINES_SVH

// Concurrent checks on clk, disabled while rst is high.
`define RID_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define RID_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define RID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rid_pkg.sv @@
package rid_pkg;

  localparam int DEFAULT_MAX_LENGTH   = 64;
  localparam int DEFAULT_TWIDDLE_BITS = 16;

  localparam int CFG_W    = 7;
  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 22;
  localparam int BIN_W    = 6;

  localparam logic [CFG_W-1:0] LENGTH_RESET = 7'd64;

  localparam int SUM_MAX = 2097151;
  localparam int SUM_MIN = -2097152;

  // Phase in units of 2^-32 turn; CORDIC in Q1.30 on 32-bit signed words.
  localparam int PHASE_W      = 32;
  localparam int CORDIC_W     = 32;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_GAIN  = 652032874;

  localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
    30'd20,        30'd10,        30'd5
  };

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_DIV,
    ST_TW_START,
    ST_TW_WAIT,
    ST_MAC,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load_sample;
    logic tw_init;
    logic mac_init;
    logic div_step;
    logic cordic_start;
    logic tw_write;
    logic mac_issue;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic block_full;
    logic tw_hit;
    logic div_done;
    logic cordic_done;
    logic tw_last;
    logic j_last;
    logic k_last;
    logic pipe_idle;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/rid_ram.sv @@
module rid_ram #(
  parameter int WIDTH = rid_pkg::SAMPLE_W,
  parameter int DEPTH = rid_pkg::DEFAULT_MAX_LENGTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/rid_cordic.sv @@
module rid_cordic #(
  parameter int TWIDDLE_BITS = rid_pkg::DEFAULT_TWIDDLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rid_pkg::PHASE_W-1:0]       phase,
  output logic                              done,
  output logic signed [TWIDDLE_BITS-1:0]    cos_q,
  output logic signed [TWIDDLE_BITS-1:0]    sin_q
);

  import rid_pkg::*;

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int FRAC   = TWIDDLE_BITS - 1;
  localparam int QSH    = CORDIC_FRAC - FRAC;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic signed [CORDIC_W-1:0] QHALF = CORDIC_W'(1) <<< (QSH - 1);
  localparam logic signed [CORDIC_W-1:0] QMAX  = (CORDIC_W'(1) <<< FRAC) - CORDIC_W'(1);
  localparam logic signed [CORDIC_W-1:0] QMIN  = -(CORDIC_W'(1) <<< FRAC);

  logic                       busy;
  logic [STEP_W-1:0]          step;
  logic signed [CORDIC_W-1:0] x, y, z;
  logic signed [CORDIC_W-1:0] dx, dy, angle;
  logic signed [CORDIC_W-1:0] xr, yr;
  logic [1:0]                 quad;

  function automatic logic signed [TWIDDLE_BITS-1:0] quant(
    input logic signed [CORDIC_W-1:0] v
  );
    logic signed [CORDIC_W-1:0] r;
    r = (v + QHALF) >>> QSH;
    if (r > QMAX) begin
      r = QMAX;
    end else if (r < QMIN) begin
      r = QMIN;
    end
    return TWIDDLE_BITS'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && step == STEP_LAST) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  assign dx    = y >>> step;
  assign dy    = x >>> step;
  assign angle = $signed({2'b00, ATAN_TURNS[step]});

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_W'(CORDIC_GAIN);
      y    <= '0;
      z    <= $signed({2'b00, phase[CORDIC_FRAC-1:0]});
      quad <= phase[PHASE_W-1 -: 2];
      step <= '0;
    end else if (busy) begin
      // rotate toward the residual angle
      if (!z[CORDIC_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - angle;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + angle;
      end
      step <= step + STEP_W'(1);
    end
  end

  always_comb begin
    case (quad)
      2'd0: begin
        xr = x;
        yr = y;
      end
      2'd1: begin
        xr = -y;
        yr = x;
      end
      2'd2: begin
        xr = -x;
        yr = -y;
      end
      default: begin
        xr = y;
        yr = -x;
      end
    endcase
  end

  assign cos_q = quant(xr);
  assign sin_q = quant(yr);

endmodule

@@ sv/rid_datapath.sv @@
module rid_datapath #(
  parameter int MAX_LENGTH   = rid_pkg::DEFAULT_MAX_LENGTH,
  parameter int TWIDDLE_BITS = rid_pkg::DEFAULT_TWIDDLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rid_pkg::ctrl_cmd_t                 cmd,
  output rid_pkg::dp_status_t                status,
  input  logic                               cfg_valid,
  input  logic [rid_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [rid_pkg::SAMPLE_W-1:0] sample,
  input  logic                               result_ready,
  output logic                               result_valid,
  output logic signed [rid_pkg::OUT_W-1:0]   real_part,
  output logic signed [rid_pkg::OUT_W-1:0]   imag_part,
  output logic [rid_pkg::BIN_W-1:0]          bin_index,
  output logic                               last_bin
);

  import rid_pkg::*;

  localparam int IDX_W     = $clog2(MAX_LENGTH);
  localparam int CNT_W     = $clog2(MAX_LENGTH + 1);
  localparam int FRAC      = TWIDDLE_BITS - 1;
  localparam int PROD_W    = SAMPLE_W + TWIDDLE_BITS;
  localparam int TERM_W    = SAMPLE_W + 1;
  localparam int ACC_W     = TERM_W + $clog2(MAX_LENGTH);
  localparam int SAT_W     = (ACC_W > OUT_W) ? ACC_W : OUT_W;
  localparam int DIV_CNT_W = $clog2(PHASE_W + 1);
  localparam int TW_W      = 2 * TWIDDLE_BITS;

  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (FRAC - 1);
  localparam logic signed [SAT_W-1:0]  SAT_HI    = SAT_W'(SUM_MAX);
  localparam logic signed [SAT_W-1:0]  SAT_LO    = SAT_W'(SUM_MIN);
  localparam logic [CNT_W-1:0]         LEN_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0]         LEN_MAX   = CNT_W'(MAX_LENGTH);
  localparam logic [DIV_CNT_W-1:0]     DIV_TOP   = DIV_CNT_W'(PHASE_W);

  logic [CFG_W-1:0] transform_length;
  logic [CNT_W-1:0] n_cur, n_blk, loaded, loaded_inc;
  logic [IDX_W-1:0] n_last;

  // twiddle table build
  logic [CNT_W-1:0]     div_rem, div_rem_next, ph_r, ph_r_next;
  logic [CNT_W:0]       div_trial, sum_r;
  logic                 div_bit;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [PHASE_W-1:0]   q0, ph_q, ph_q_next;
  logic [IDX_W-1:0]     m_tw;
  logic                 tw_valid;
  logic [CNT_W-1:0]     tw_len;
  logic                 cordic_done;
  logic signed [TWIDDLE_BITS-1:0] cos_q, sin_q;

  // multiply-accumulate
  logic [IDX_W-1:0]   j, k, m_mac, m_next;
  logic [IDX_W:0]     m_sum;
  logic [SAMPLE_W-1:0] samp_rdata;
  logic [TW_W-1:0]    tw_rdata;
  logic               v1, v2, first1, first2;
  logic signed [SAMPLE_W-1:0]     y_rd;
  logic signed [TWIDDLE_BITS-1:0] c_rd, s_rd;
  logic signed [PROD_W-1:0] prod_c, prod_s, rnd_c, rnd_s;
  logic signed [TERM_W-1:0] term_c, term_s;
  logic signed [ACC_W-1:0]  acc_re, acc_im;

  function automatic logic signed [OUT_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
    logic signed [SAT_W-1:0] w;
    w = SAT_W'(v);
    if (w > SAT_HI) begin
      w = SAT_HI;
    end else if (w < SAT_LO) begin
      w = SAT_LO;
    end
    return OUT_W'(w);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      transform_length <= LENGTH_RESET;
    end else if (cfg_valid) begin
      transform_length <= cfg_data;
    end
  end

  always_comb begin
    if (transform_length < CFG_W'(2)) begin
      n_cur = LEN_MIN;
    end else if (transform_length > CFG_W'(MAX_LENGTH)) begin
      n_cur = LEN_MAX;
    end else begin
      n_cur = CNT_W'(transform_length);
    end
  end

  assign loaded_inc = loaded + CNT_W'(1);
  assign n_last     = IDX_W'(n_blk - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (cmd.load_sample) begin
      loaded <= status.block_full ? '0 : loaded_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample && status.block_full) begin
      n_blk <= n_cur;
    end
  end

  rid_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_LENGTH)
  ) u_sample_ram (
    .clk  (clk),
    .we   (cmd.load_sample),
    .waddr(loaded[IDX_W-1:0]),
    .wdata(sample),
    .raddr(j),
    .rdata(samp_rdata)
  );

  // 2^32 / N, one quotient bit per step; the dividend has a single set bit
  assign div_bit   = (div_cnt == DIV_TOP);
  assign div_trial = {div_rem, div_bit};
  assign div_rem_next = (div_trial >= {1'b0, n_blk}) ?
                        CNT_W'(div_trial - {1'b0, n_blk}) : CNT_W'(div_trial);

  // phase of the next entry: add quotient and remainder of 2^32 / N
  assign sum_r = {1'b0, ph_r} + {1'b0, div_rem};
  always_comb begin
    if (sum_r >= {1'b0, n_blk}) begin
      ph_r_next = CNT_W'(sum_r - {1'b0, n_blk});
      ph_q_next = ph_q + q0 + PHASE_W'(1);
    end else begin
      ph_r_next = CNT_W'(sum_r);
      ph_q_next = ph_q + q0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tw_init) begin
      div_rem <= '0;
      q0      <= '0;
      div_cnt <= DIV_TOP;
      ph_q    <= '0;
      ph_r    <= n_blk >> 1;
      m_tw    <= '0;
    end else if (cmd.div_step) begin
      div_rem <= div_rem_next;
      q0      <= {q0[PHASE_W-2:0], (div_trial >= {1'b0, n_blk})};
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end else if (cmd.tw_write) begin
      ph_q <= ph_q_next;
      ph_r <= ph_r_next;
      m_tw <= m_tw + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tw_valid <= 1'b0;
    end else if (cmd.tw_write && status.tw_last) begin
      tw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tw_write && status.tw_last) begin
      tw_len <= n_blk;
    end
  end

  rid_cordic #(
    .TWIDDLE_BITS(TWIDDLE_BITS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.cordic_start),
    .phase(ph_q),
    .done (cordic_done),
    .cos_q(cos_q),
    .sin_q(sin_q)
  );

  rid_ram #(
    .WIDTH(TW_W),
    .DEPTH(MAX_LENGTH)
  ) u_twiddle_ram (
    .clk  (clk),
    .we   (cmd.tw_write),
    .waddr(m_tw),
    .wdata({cos_q, sin_q}),
    .raddr(m_mac),
    .rdata(tw_rdata)
  );

  // twiddle index (k * j) mod N, stepped by k
  assign m_sum  = {1'b0, m_mac} + {1'b0, k};
  assign m_next = (m_sum >= n_blk) ? IDX_W'(m_sum - n_blk) : IDX_W'(m_sum);

  always_ff @(posedge clk) begin
    if (cmd.mac_init) begin
      j     <= '0;
      k     <= '0;
      m_mac <= '0;
    end else if (cmd.mac_issue) begin
      j     <= j + IDX_W'(1);
      m_mac <= m_next;
    end else if (cmd.emit) begin
      j     <= '0;
      k     <= k + IDX_W'(1);
      m_mac <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_issue;
      v2 <= v1;
    end
  end

  assign y_rd = $signed(samp_rdata);
  assign c_rd = $signed(tw_rdata[TW_W-1 -: TWIDDLE_BITS]);
  assign s_rd = $signed(tw_rdata[TWIDDLE_BITS-1:0]);

  always_ff @(posedge clk) begin
    first1 <= (j == '0);
    first2 <= first1;
    prod_c <= y_rd * c_rd;
    prod_s <= y_rd * s_rd;
  end

  assign rnd_c  = prod_c + PROD_HALF;
  assign rnd_s  = prod_s + PROD_HALF;
  assign term_c = TERM_W'(rnd_c >>> FRAC);
  assign term_s = TERM_W'(rnd_s >>> FRAC);

  always_ff @(posedge clk) begin
    if (v2) begin
      acc_re <= first2 ? ACC_W'(term_c) : acc_re + ACC_W'(term_c);
      acc_im <= first2 ? -ACC_W'(term_s) : acc_im - ACC_W'(term_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      real_part <= sat_sum(acc_re);
      imag_part <= sat_sum(acc_im);
      bin_index <= BIN_W'(k);
      last_bin  <= (k == n_last);
    end
  end

  always_comb begin
    status.block_full  = (loaded_inc >= n_cur);
    status.tw_hit      = tw_valid && (tw_len == n_blk);
    status.div_done    = (div_cnt == '0);
    status.cordic_done = cordic_done;
    status.tw_last     = (m_tw == n_last);
    status.j_last      = (j == n_last);
    status.k_last      = (k == n_last);
    status.pipe_idle   = !v1 && !v2;
    status.out_free    = !result_valid || result_ready;
  end

endmodule

@@ sv/rid_ctrl.sv @@
module rid_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  rid_pkg::dp_status_t status,
  output rid_pkg::ctrl_cmd_t  cmd
);

  import rid_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_ready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.load_sample = 1'b1;
          if (status.block_full) begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.tw_init  = 1'b1;
        cmd.mac_init = 1'b1;
        // reuse the twiddle table when a valid one of the same length is held
        state_next   = status.tw_hit ? ST_MAC : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_TW_START;
        end
      end
      ST_TW_START: begin
        cmd.cordic_start = 1'b1;
        state_next       = ST_TW_WAIT;
      end
      ST_TW_WAIT: begin
        if (status.cordic_done) begin
          cmd.tw_write = 1'b1;
          state_next   = status.tw_last ? ST_MAC : ST_TW_START;
        end
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (status.j_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // hold until the sums settle and the output slot is free
        if (status.pipe_idle && status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.k_last ? ST_LOAD : ST_MAC;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

@@ sv/real_input_dft_engine.sv @@
// Sample load: one transaction per cycle until N samples are held.
// Per block: the bins follow the last sample one after another, each from
// one shared multiply-accumulate pass over the sample and twiddle memories.
// When no valid twiddle table for N is held (N differs from the last table's), it is first rebuilt
// (serial 2^32/N divide, then one 28-step CORDIC per entry).
// Synchronous reset: length 64, sample count zero, twiddle table stale, output empty.
`include "real_input_dft_engine_defines.svh"

module real_input_dft_engine #(
  parameter int MAX_LENGTH   = rid_pkg::DEFAULT_MAX_LENGTH,
  parameter int TWIDDLE_BITS = rid_pkg::DEFAULT_TWIDDLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rid_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic signed [rid_pkg::SAMPLE_W-1:0] sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [rid_pkg::OUT_W-1:0]    real_part,
  output logic signed [rid_pkg::OUT_W-1:0]    imag_part,
  output logic [rid_pkg::BIN_W-1:0]           bin_index,
  output logic                                last_bin
);

  import rid_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic [5:0] cmd_vec;

  assign cfg_ready = 1'b1;

  rid_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .status      (status),
    .cmd         (cmd)
  );

  rid_datapath #(
    .MAX_LENGTH  (MAX_LENGTH),
    .TWIDDLE_BITS(TWIDDLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .sample      (sample),
    .result_ready(result_ready),
    .result_valid(result_valid),
    .real_part   (real_part),
    .imag_part   (imag_part),
    .bin_index   (bin_index),
    .last_bin    (last_bin)
  );

  assign cmd_vec = {cmd.load_sample, cmd.div_step, cmd.cordic_start,
                    cmd.tw_write, cmd.mac_issue, cmd.emit};

  `RID_ASSERT_ALWAYS(a_one_cmd, $onehot0(cmd_vec), "datapath commands overlap")
  `RID_ASSERT_IMPLY(a_emit_safe, cmd.emit, status.pipe_idle && status.out_free, "bin emitted early")
  `RID_ASSERT_IMPLY(a_tw_write_done, cmd.tw_write, status.cordic_done, "twiddle not ready")
  `RID_ASSERT_NEXT(a_block_closes, cmd.load_sample && status.block_full, !sample_ready, "load after block")

endmodule

@@ verif/real_input_dft_engine_tb.sv @@
`timescale 1ns / 1ps

module real_input_dft_engine_tb;

  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 2100;
  localparam int QUIET_LIMIT = 20000;
  localparam int ITEM_TARGET = 350;
  localparam longint BIN_MAX = 2097151;
  localparam longint BIN_MIN = -2097152;

  typedef struct {
    logic signed [21:0] re;
    logic signed [21:0] im;
    logic [5:0] k;
    logic last;
  } dft_bin_t;

  class bin_scoreboard;
    logic signed [15:0] held [64];
    int unsigned loaded;
    logic [6:0] length_reg;
    longint atan_turns [28];
    longint tw_cos [64];
    longint tw_sin [64];
    int unsigned table_n;
    dft_bin_t pending_bins [$];
    int errors;
    int bins_seen;
    int blocks_done;
    int samples_seen;

    function new();
      loaded = 0;
      length_reg = 7'd64;
      table_n = 0;
      errors = 0;
      bins_seen = 0;
      blocks_done = 0;
      samples_seen = 0;
      foreach (held[i]) held[i] = '0;
      atan_turns = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                     10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                     83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                     81, 41, 20, 10, 5};
    endfunction

    function int unsigned active_length();
      if (length_reg < 2) return 2;
      if (length_reg > 64) return 64;
      return length_reg;
    endfunction

    function void set_length(logic [6:0] v);
      length_reg = v;
    endfunction

    function longint round_twiddle(longint v);
      longint q;
      q = (v + 16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
    endfunction

    // cos/sin(2*pi*m/n) by a 28-step CORDIC on the phase in 2^-32 turn
    function void build_twiddles(int unsigned n);
      longint p, x, y, z, dx, dy, t;
      int unsigned quad;
      if (n == table_n) return;
      for (int m = 0; m < n; m++) begin
        p = ((longint'(m) <<< 32) + (n >> 1)) / n;
        quad = int'((p >>> 30) & 3);
        z = p & 64'h3FFF_FFFF;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 28; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_turns[i];
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_turns[i];
          end
        end
        case (quad)
          1: begin
            t = x;
            x = -y;
            y = t;
          end
          2: begin
            x = -x;
            y = -y;
          end
          3: begin
            t = x;
            x = y;
            y = -t;
          end
          default: ;
        endcase
        tw_cos[m] = round_twiddle(x);
        tw_sin[m] = round_twiddle(y);
      end
      table_n = n;
    endfunction

    function void predict_block(int unsigned n);
      longint re, im, smp;
      int unsigned m;
      dft_bin_t e;
      build_twiddles(n);
      for (int unsigned k = 0; k < n; k++) begin
        re = 0;
        im = 0;
        for (int unsigned j = 0; j < n; j++) begin
          smp = longint'(held[j]);
          m = (k * j) % n;
          re = re + ((smp * tw_cos[m] + 16384) >>> 15);
          im = im - ((smp * tw_sin[m] + 16384) >>> 15);
        end
        if (re > BIN_MAX) re = BIN_MAX;
        if (re < BIN_MIN) re = BIN_MIN;
        if (im > BIN_MAX) im = BIN_MAX;
        if (im < BIN_MIN) im = BIN_MIN;
        e.re = re[21:0];
        e.im = im[21:0];
        e.k = k[5:0];
        e.last = (k + 1 == n);
        pending_bins.push_back(e);
      end
    endfunction

    // Length applies at once: a block may close with entries beyond n left unused.
    function void note_sample(logic signed [15:0] v);
      int unsigned n;
      n = active_length();
      samples_seen++;
      if (loaded < 64) begin
        held[loaded] = v;
        loaded++;
      end
      if (loaded >= n) begin
        predict_block(n);
        loaded = 0;
        blocks_done++;
      end
    endfunction

    task report_mismatch(input string what);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_bin(input logic signed [21:0] re, input logic signed [21:0] im,
                   input logic [5:0] k, input logic last);
      dft_bin_t e;
      bins_seen++;
      if (pending_bins.size() == 0) begin
        report_mismatch($sformatf("bin %0d arrived with nothing expected", k));
        return;
      end
      e = pending_bins.pop_front();
      if (re !== e.re)
        report_mismatch($sformatf("bin %0d real_part %0d, want %0d", e.k, re, e.re));
      if (im !== e.im)
        report_mismatch($sformatf("bin %0d imag_part %0d, want %0d", e.k, im, e.im));
      if (k !== e.k)
        report_mismatch($sformatf("bin_index %0d, want %0d", k, e.k));
      if (last !== e.last)
        report_mismatch($sformatf("bin %0d last_bin %0b, want %0b", e.k, last, e.last));
    endtask

    function int pending();
      return pending_bins.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_data;
  logic sample_valid;
  logic sample_ready;
  logic signed [15:0] sample;
  logic result_valid;
  logic result_ready;
  logic signed [21:0] real_part;
  logic signed [21:0] imag_part;
  logic [5:0] bin_index;
  logic last_bin;

  bin_scoreboard sb = new();
  bit no_idle = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int length_writes = 0;

  real_input_dft_engine uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .real_part(real_part),
    .imag_part(imag_part),
    .bin_index(bin_index),
    .last_bin(last_bin)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (sample_valid && sample_ready) ||
        (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: check each transaction, then pick ready for the next edge.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready)
        sb.check_bin(real_part, imag_part, bin_index, last_bin);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (no_idle) begin
        result_ready <= 1'b1;
      end else begin
        result_ready <= ($urandom_range(99) >= 10);
      end
    end
  end

  task automatic write_length(input logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_length(v);
    length_writes++;
  endtask

  // Leave valid high on return so back-to-back transactions need no gap.
  task automatic send_sample(input logic signed [15:0] v);
    int gap;
    if (!no_idle && $urandom_range(99) < 10) begin
      gap = $urandom_range(1, 3);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (!sample_ready);
    sb.note_sample(v);
  endtask

  task automatic drain(input int settle);
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 15) return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
    if (r < 30) return 16'($urandom_range(31)) - 16'sd16;
    return 16'($urandom);
  endfunction

  initial begin
    int unsigned n, count, nblocks, phase;
    int r;
    logic [6:0] len_val;
    logic signed [15:0] fill;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sample_valid = 1'b0;
    sample = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Extremes on the shortest block, with lengths below the legal range, then lengths 3 and 7.
    write_length(7'd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain(SETTLE_CYCLES);
    write_length(7'd1);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    drain(SETTLE_CYCLES);
    write_length(7'd3);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    drain(SETTLE_CYCLES);
    write_length(7'd7);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh00FF);
    send_sample(16'shFF00);
    send_sample(16'sh1234);
    drain(SETTLE_CYCLES);

    // Shorten the length mid-block: the next sample closes the block.
    write_length(7'd127);
    repeat (5) send_sample(pick_sample());
    drain(SETTLE_CYCLES);
    write_length(7'd4);
    send_sample(pick_sample());
    drain(SETTLE_CYCLES);
    write_length(7'd5);
    repeat (2) send_sample(pick_sample());
    drain(SETTLE_CYCLES);
    write_length(7'd2);
    send_sample(pick_sample());
    drain(SETTLE_CYCLES);

    phase = 0;
    while (sb.samples_seen < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (phase == 2) len_val = 7'd8;
      else if (r < 55) len_val = 7'($urandom_range(2, 16));
      else if (r < 75) len_val = 7'($urandom_range(17, 63));
      else if (r < 85) len_val = 7'($urandom_range(64, 127));
      else if (r < 92) len_val = 7'($urandom_range(0, 1));
      else len_val = 7'd64;
      write_length(len_val);
      n = sb.active_length();
      no_idle = (phase >= 5 && phase <= 8);
      nblocks = (n <= 16 && $urandom_range(1) != 0) ? 2 : 1;
      if (phase == 2) begin
        nblocks = 4;
        hold_req = 1;
      end
      count = ((sb.loaded >= n) ? 1 : n - sb.loaded) + (nblocks - 1) * n;
      r = $urandom_range(99);
      if (r < 75 || phase == 2) begin
        repeat (count) send_sample(pick_sample());
      end else if (r < 85) begin
        // Full-scale block: every sample sent is the largest positive or negative value.
        fill = ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
        repeat (count) send_sample(fill);
      end else begin
        count = $urandom_range(1, n - 1);
        repeat (count) send_sample(pick_sample());
      end
      drain(SETTLE_CYCLES);
      phase++;
    end
    no_idle = 0;

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d bins never arrived", sb.pending()));
    $display("Run: %0d samples, %0d completed blocks, %0d bins compared, %0d errors",
             sb.samples_seen, sb.blocks_done, sb.bins_seen, sb.errors);
    $display("Run: %0d length writes incl. out-of-range codes, %0d-cycle output hold-off",
             length_writes, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
